[hdl/assert_macros.svh]
// Assertion macros for the port-level checker of the touch gesture tracker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge of clk while rst_n is high.
`define TGT_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: assertion failed");

// Checked on every rising edge of clk, reset included.
`define TGT_ASSERT_ALWAYS(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("%m: assertion failed");

`endif

[hdl/tgt_pkg.sv]
// Types, codes and reset constants of the touch gesture tracker.
package tgt_pkg;

  typedef enum logic [2:0] {
    GST_NONE      = 3'd0,
    GST_UP        = 3'd1,
    GST_DOWN      = 3'd2,
    GST_SLIDE_END = 3'd3,
    GST_SLIDE     = 3'd4
  } gesture_t;

  typedef enum logic [1:0] {
    FLT_OK     = 2'd0,
    FLT_STATUS = 2'd1,
    FLT_DATA   = 2'd2,
    FLT_RSVD   = 2'd3
  } fault_t;

  typedef enum logic [1:0] {
    REG_SLIDE_THRESHOLD = 2'd0,
    REG_TAP_WINDOW_MS   = 2'd1,
    REG_MAX_POINTS      = 2'd2,
    REG_UNUSED          = 2'd3
  } reg_idx_t;

  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 120;

  localparam logic [11:0] SLIDE_THRESHOLD_RST = 12'd10;
  localparam logic [15:0] TAP_WINDOW_MS_RST   = 16'd250;
  localparam logic [3:0]  MAX_POINTS_RST      = 4'd5;
  localparam logic [7:0]  TAP_RUN_MAX         = 8'hFF;

  typedef struct packed {
    logic [11:0] slide_threshold;
    logic [15:0] tap_window_ms;
    logic [3:0]  max_points;
  } cfg_t;

  typedef struct packed {
    logic [31:0] now_ms;
    logic [11:0] point_y;
    logic [11:0] point_x;
    logic [3:0]  point_count;
    logic        ready_req;
    logic [1:0]  fault;
    logic        irq_pending;
  } item_t;

  typedef struct packed {
    gesture_t           gesture;
    logic [11:0]        track_x;
    logic [11:0]        track_y;
    logic [11:0]        origin_x;
    logic [11:0]        origin_y;
    logic signed [12:0] move_x;
    logic signed [12:0] move_y;
    logic [7:0]         reported_taps;
    logic [7:0]         tap_run;
    logic [31:0]        press_time;
    logic [31:0]        last_tap_time;
    logic [31:0]        fault_total;
  } state_t;

endpackage

[hdl/touch_gesture_tracker.sv]
// Top level of the touch gesture tracker: stream handshake, input stage and result framing.
//
// Each input transfer on in_* is one poll of a touch controller; every poll
// yields exactly one result transfer on out_* carrying the whole touch state
// (gesture code, tracked and start positions, deltas, tap count, fault count).
// The configuration channel cfg_* writes slide_threshold (index 0),
// tap_window_ms (index 1) and max_points (index 2); cfg_ready is always high,
// and other indexes are ignored. Write it only while no poll is in flight.
// A poll taken into the input register moves into the state registers, which
// drive out_tdata, once the result slot is free. One poll per cycle while
// out_tready is high: the gesture update is a single pass of compare-and-add
// logic between the input and state registers, the latter doubling as result.
// When the receiver holds out_tready low, the result stays put and one more
// poll can wait in the input register; in_tready then drops until the result
// is taken. Synchronous reset clears the gesture state, counters and both
// valid flags and restores the register defaults (10, 250, 5).
module touch_gesture_tracker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [0] irq_pending, [2:1] fault, [3] ready_req, [7:4] point_count,
  // [19:8] point_x, [31:20] point_y, [63:32] now_ms
  input  logic [tgt_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [2:0] event_res, [14:3] cur_x, [26:15] cur_y, [38:27] start_x,
  // [50:39] start_y, [63:51] delta_x, [76:64] delta_y, [84:77] tap_count,
  // [116:85] fault_count, [119:117] zero
  output logic [tgt_pkg::OUT_DATA_W-1:0]    out_tdata,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [1:0]                        cfg_index,
  input  logic [tgt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  tgt_pkg::cfg_t   cfg;
  tgt_pkg::state_t state;
  tgt_pkg::item_t  item_r;
  logic            item_valid_r;
  logic            out_valid_r;
  logic            advance;
  logic            in_xfer;

  // The result slot frees up when it is empty or being taken this cycle.
  assign advance   = !out_valid_r || out_tready;
  assign in_tready = !item_valid_r || advance;
  assign in_xfer   = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (in_tready) begin
        item_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= item_valid_r;
      end
    end
  end

  // Payload register, no reset needed.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      item_r <= tgt_pkg::item_t'(in_tdata);
    end
  end

  tgt_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // The state only moves when the poll it belongs to lands in the result slot.
  tgt_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance && item_valid_r),
    .item  (item_r),
    .cfg   (cfg),
    .state (state)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000,
                       state.fault_total,
                       state.reported_taps,
                       state.move_y,
                       state.move_x,
                       state.origin_y,
                       state.origin_x,
                       state.track_y,
                       state.track_x,
                       state.gesture};

endmodule

[hdl/tgt_cfg_regs.sv]
// Configuration register file of the touch gesture tracker.
module tgt_cfg_regs (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  input  logic [1:0]                         cfg_index,
  input  logic [tgt_pkg::CFG_DATA_W-1:0]     cfg_data,
  output tgt_pkg::cfg_t                      cfg
);

  tgt_pkg::cfg_t cfg_r;
  tgt_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (tgt_pkg::reg_idx_t'(cfg_index))
        tgt_pkg::REG_SLIDE_THRESHOLD: cfg_nxt.slide_threshold = cfg_data[11:0];
        tgt_pkg::REG_TAP_WINDOW_MS:   cfg_nxt.tap_window_ms   = cfg_data[15:0];
        tgt_pkg::REG_MAX_POINTS:      cfg_nxt.max_points      = cfg_data[3:0];
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slide_threshold <= tgt_pkg::SLIDE_THRESHOLD_RST;
      cfg_r.tap_window_ms   <= tgt_pkg::TAP_WINDOW_MS_RST;
      cfg_r.max_points      <= tgt_pkg::MAX_POINTS_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

[hdl/tgt_core.sv]
// Gesture state update: one poll item per enabled cycle, state registers double as result.
module tgt_core (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            step,
  input  tgt_pkg::item_t  item,
  input  tgt_pkg::cfg_t   cfg,
  output tgt_pkg::state_t state
);

  tgt_pkg::state_t    st_r;
  tgt_pkg::state_t    st_nxt;
  logic signed [12:0] dx;
  logic signed [12:0] dy;
  logic [12:0]        dx_neg;
  logic [12:0]        dy_neg;
  logic [11:0]        mag_x;
  logic [11:0]        mag_y;
  logic               slide_hit;
  logic               count_ok;
  logic [31:0]        press_age;
  logic [31:0]        tap_gap;
  logic               is_tap;
  logic               run_restart;

  assign dx     = $signed({1'b0, item.point_x}) - $signed({1'b0, st_r.track_x});
  assign dy     = $signed({1'b0, item.point_y}) - $signed({1'b0, st_r.track_y});
  assign dx_neg = 13'(-dx);
  assign dy_neg = 13'(-dy);
  assign mag_x  = dx[12] ? dx_neg[11:0] : dx[11:0];
  assign mag_y  = dy[12] ? dy_neg[11:0] : dy[11:0];
  assign slide_hit = (mag_x >= cfg.slide_threshold) || (mag_y >= cfg.slide_threshold);

  assign count_ok    = (item.point_count != 4'd0) && (item.point_count <= cfg.max_points);
  assign press_age   = item.now_ms - st_r.press_time;
  assign tap_gap     = item.now_ms - st_r.last_tap_time;
  assign is_tap      = press_age <= {16'd0, cfg.tap_window_ms};
  assign run_restart = tap_gap > {16'd0, cfg.tap_window_ms};

  always_comb begin
    st_nxt = st_r;
    if (item.irq_pending) begin
      if (tgt_pkg::fault_t'(item.fault) == tgt_pkg::FLT_STATUS) begin
        st_nxt.fault_total = st_r.fault_total + 32'd1;
      end else begin
        st_nxt.move_x = '0;
        st_nxt.move_y = '0;
        if (item.ready_req) begin
          st_nxt.reported_taps = '0;
          if (count_ok) begin
            if (tgt_pkg::fault_t'(item.fault) == tgt_pkg::FLT_DATA) begin
              st_nxt.fault_total = st_r.fault_total + 32'd1;
            end else begin
              unique case (st_r.gesture)
                tgt_pkg::GST_NONE, tgt_pkg::GST_UP, tgt_pkg::GST_SLIDE_END: begin
                  st_nxt.gesture    = tgt_pkg::GST_DOWN;
                  st_nxt.origin_x   = item.point_x;
                  st_nxt.origin_y   = item.point_y;
                  st_nxt.track_x    = item.point_x;
                  st_nxt.track_y    = item.point_y;
                  st_nxt.press_time = item.now_ms;
                end
                default: begin
                  // Down or slide: report the movement, slide once far enough.
                  st_nxt.move_x = dx;
                  st_nxt.move_y = dy;
                  if (st_r.gesture == tgt_pkg::GST_SLIDE || slide_hit) begin
                    st_nxt.gesture = tgt_pkg::GST_SLIDE;
                    st_nxt.track_x = item.point_x;
                    st_nxt.track_y = item.point_y;
                  end
                end
              endcase
            end
          end else begin
            unique case (st_r.gesture)
              tgt_pkg::GST_SLIDE: st_nxt.gesture = tgt_pkg::GST_SLIDE_END;
              tgt_pkg::GST_DOWN: begin
                st_nxt.gesture = tgt_pkg::GST_UP;
                if (is_tap) begin
                  if (run_restart) begin
                    st_nxt.tap_run = 8'd1;
                  end else if (st_r.tap_run != tgt_pkg::TAP_RUN_MAX) begin
                    st_nxt.tap_run = st_r.tap_run + 8'd1;
                  end
                  st_nxt.reported_taps = run_restart ? 8'd1 :
                    ((st_r.tap_run != tgt_pkg::TAP_RUN_MAX) ? st_r.tap_run + 8'd1
                                                             : st_r.tap_run);
                  st_nxt.last_tap_time = item.now_ms;
                end
              end
              default: st_nxt.gesture = tgt_pkg::GST_NONE;
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (step) begin
      st_r <= st_nxt;
    end
  end

  assign state = st_r;

endmodule

[hdl/tgt_checker.sv]
// Port-level checker of the touch gesture tracker and its bind.
`include "assert_macros.svh"

module tgt_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_tvalid,
  input logic                              in_tready,
  input logic [tgt_pkg::IN_DATA_W-1:0]     in_tdata,
  input logic                              out_tvalid,
  input logic                              out_tready,
  input logic [tgt_pkg::OUT_DATA_W-1:0]    out_tdata,
  input logic                              cfg_valid,
  input logic                              cfg_ready,
  input logic [1:0]                        cfg_index,
  input logic [tgt_pkg::CFG_DATA_W-1:0]    cfg_data
);

  logic unused_ok;
  assign unused_ok = ^{in_tvalid, in_tdata, cfg_valid, cfg_ready, cfg_index, cfg_data};

  // Reset leaves no result pending.
  `TGT_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_tvalid)

  // A stalled result is held unchanged.
  `TGT_ASSERT(a_stall_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))

  // With no result pending the input side is always open.
  `TGT_ASSERT(a_ready_when_empty, !out_tvalid |-> in_tready)

  // A tap count is only ever reported together with the up gesture.
  `TGT_ASSERT(a_taps_on_up,
    out_tvalid && (out_tdata[84:77] != 8'd0) |-> (out_tdata[2:0] == tgt_pkg::GST_UP))

  // Movement is only reported while pressed (down or slide).
  `TGT_ASSERT(a_delta_when_pressed,
    out_tvalid && ((out_tdata[63:51] != 13'd0) || (out_tdata[76:64] != 13'd0)) |->
      (out_tdata[2:0] == tgt_pkg::GST_DOWN) || (out_tdata[2:0] == tgt_pkg::GST_SLIDE))

endmodule

bind touch_gesture_tracker tgt_checker u_tgt_checker (.*);

[bench/touch_state_checker.sv]
// Checker that follows the tracker's transfers, predicts each touch report and compares it.
`timescale 1ns / 100ps

module touch_state_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [tgt_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [tgt_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [tgt_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic [31:0]                    mismatch_total,
  output logic [31:0]                    reports_owed
);
  import tgt_pkg::*;

  // Layout of one report on out_tdata, lowest field last.
  typedef struct packed {
    logic [2:0]         pad;
    logic [31:0]        fault_count;
    logic [7:0]         tap_count;
    logic signed [12:0] delta_y;
    logic signed [12:0] delta_x;
    logic [11:0]        start_y;
    logic [11:0]        start_x;
    logic [11:0]        cur_y;
    logic [11:0]        cur_x;
    logic [2:0]         event_res;
  } touch_report_t;

  state_t        trk;
  cfg_t          knobs;
  touch_report_t expected_states[$];

  // Applies one poll to the predicted touch state and returns the report it yields.
  function automatic touch_report_t advance_touch_state(item_t poll);
    touch_report_t r;
    int            dx, dy, abs_dx, abs_dy;
    logic [31:0]   held, gap;
    logic          count_ok;
    count_ok = poll.point_count != 4'd0 && poll.point_count <= knobs.max_points;
    if (poll.irq_pending) begin
      if (poll.fault == FLT_STATUS) begin
        trk.fault_total = trk.fault_total + 32'd1;
      end else begin
        trk.move_x = '0;
        trk.move_y = '0;
        if (poll.ready_req) begin
          trk.reported_taps = '0;
          if (count_ok && poll.fault == FLT_DATA) begin
            trk.fault_total = trk.fault_total + 32'd1;
          end else if (count_ok) begin
            if (trk.gesture == GST_NONE || trk.gesture == GST_UP ||
                trk.gesture == GST_SLIDE_END) begin
              trk.gesture    = GST_DOWN;
              trk.origin_x   = poll.point_x;
              trk.track_x    = poll.point_x;
              trk.origin_y   = poll.point_y;
              trk.track_y    = poll.point_y;
              trk.press_time = poll.now_ms;
            end else begin
              dx = int'(poll.point_x) - int'(trk.track_x);
              dy = int'(poll.point_y) - int'(trk.track_y);
              abs_dx = dx < 0 ? -dx : dx;
              abs_dy = dy < 0 ? -dy : dy;
              trk.move_x = dx[12:0];
              trk.move_y = dy[12:0];
              if (trk.gesture == GST_SLIDE || abs_dx >= int'(knobs.slide_threshold) ||
                  abs_dy >= int'(knobs.slide_threshold)) begin
                trk.gesture = GST_SLIDE;
                trk.track_x = poll.point_x;
                trk.track_y = poll.point_y;
              end
            end
          end else if (trk.gesture == GST_SLIDE) begin
            trk.gesture = GST_SLIDE_END;
          end else if (trk.gesture == GST_DOWN) begin
            trk.gesture = GST_UP;
            held = poll.now_ms - trk.press_time;
            gap  = poll.now_ms - trk.last_tap_time;
            if (held <= {16'd0, knobs.tap_window_ms}) begin
              if (gap > {16'd0, knobs.tap_window_ms}) begin
                trk.tap_run = 8'd1;
              end else if (trk.tap_run != TAP_RUN_MAX) begin
                trk.tap_run = trk.tap_run + 8'd1;
              end
              trk.reported_taps = trk.tap_run;
              trk.last_tap_time = poll.now_ms;
            end
          end else begin
            trk.gesture = GST_NONE;
          end
        end
      end
    end
    r.pad         = '0;
    r.fault_count = trk.fault_total;
    r.tap_count   = trk.reported_taps;
    r.delta_y     = trk.move_y;
    r.delta_x     = trk.move_x;
    r.start_y     = trk.origin_y;
    r.start_x     = trk.origin_x;
    r.cur_y       = trk.track_y;
    r.cur_x       = trk.track_x;
    r.event_res   = trk.gesture;
    return r;
  endfunction

  task automatic check_field(input string label, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
      mismatch_total = mismatch_total + 32'd1;
    end
  endtask

  always @(posedge clk) begin : watch
    touch_report_t got, want;
    if (!rst_n) begin
      trk                   = '0;
      knobs.slide_threshold = SLIDE_THRESHOLD_RST;
      knobs.tap_window_ms   = TAP_WINDOW_MS_RST;
      knobs.max_points      = MAX_POINTS_RST;
      expected_states.delete();
      mismatch_total        = '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SLIDE_THRESHOLD: knobs.slide_threshold = cfg_data[11:0];
          REG_TAP_WINDOW_MS:   knobs.tap_window_ms   = cfg_data[15:0];
          REG_MAX_POINTS:      knobs.max_points      = cfg_data[3:0];
          default: ;
        endcase
      end
      // A result always belongs to an earlier poll, so pop before pushing this edge's poll.
      if (out_tvalid && out_tready) begin
        got = out_tdata;
        if (expected_states.size() == 0) begin
          $display("%0t ns: unexpected report, expected none, actual %h", $time, got);
          mismatch_total = mismatch_total + 32'd1;
        end else begin
          want = expected_states.pop_front();
          check_field("event_res",   want.event_res,   got.event_res);
          check_field("cur_x",       want.cur_x,       got.cur_x);
          check_field("cur_y",       want.cur_y,       got.cur_y);
          check_field("start_x",     want.start_x,     got.start_x);
          check_field("start_y",     want.start_y,     got.start_y);
          check_field("delta_x",     want.delta_x,     got.delta_x);
          check_field("delta_y",     want.delta_y,     got.delta_y);
          check_field("tap_count",   want.tap_count,   got.tap_count);
          check_field("fault_count", want.fault_count, got.fault_count);
          check_field("pad",         want.pad,         got.pad);
        end
      end
      if (in_tvalid && in_tready) begin
        expected_states.push_back(advance_touch_state(item_t'(in_tdata)));
      end
    end
    reports_owed = expected_states.size();
  end

endmodule

[bench/tb_touch_gesture_tracker.sv]
// Top of the touch gesture tracker bench: clock, reset, poll and register stimulus, verdict.
`timescale 1ns / 100ps

module tb_touch_gesture_tracker;
  import tgt_pkg::*;

  localparam int HOLD_CYCLES = 150;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [1:0]            cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic [31:0]           mismatch_total;
  logic [31:0]           reports_owed;

  // Register values currently programmed, as the stimulus needs them to shape polls.
  int          thr_now;
  int          win_now;
  int          max_now;
  // Where the simulated finger is and the controller's millisecond tick.
  int          fx;
  int          fy;
  bit          finger_down;
  logic [31:0] clock_ms;
  // Random idling on each side; both are switched off for one long phase.
  bit          in_gaps;
  bit          out_gaps;
  // Each increment asks the receiver for one long hold-off.
  int          park_asks;

  touch_gesture_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  touch_state_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_tvalid      (in_tvalid),
    .in_tready      (in_tready),
    .in_tdata       (in_tdata),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_tdata      (out_tdata),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .mismatch_total (mismatch_total),
    .reports_owed   (reports_owed)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Presents one poll from the falling edge, optionally after a few idle cycles, and
  // returns just after the rising edge at which the transfer took place.
  task automatic offer_poll(input item_t p);
    @(negedge clk);
    while (in_gaps && $urandom_range(99) < 17) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= p;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic poke(input bit irq, input logic [1:0] flt, input bit rdy, input int cnt,
                      input int x, input int y, input logic [31:0] ms);
    item_t p;
    p.irq_pending = irq;
    p.fault       = flt;
    p.ready_req   = rdy;
    p.point_count = cnt[3:0];
    p.point_x     = x[11:0];
    p.point_y     = y[11:0];
    p.now_ms      = ms;
    offer_poll(p);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Raw values go out as given; the block keeps only the low bits of the threshold and point registers.
  task automatic set_knobs(input logic [15:0] thr, input logic [15:0] win,
                           input logic [15:0] pts);
    cfg_write(REG_SLIDE_THRESHOLD, thr);
    cfg_write(REG_TAP_WINDOW_MS, win);
    cfg_write(REG_MAX_POINTS, pts);
    thr_now = thr[11:0];
    win_now = win;
    max_now = pts[3:0];
  endtask

  // Stops offering polls and waits until every report has been taken, plus some
  // margin, so registers can be written safely.
  task automatic drain();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (reports_owed != 0) @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic int clamp_coord(input int v);
    return v < 0 ? 0 : (v > 4095 ? 4095 : v);
  endfunction

  // Time between polls: mostly inside the tap window, sometimes just past it.
  function automatic int ms_step();
    int r;
    r = $urandom_range(99);
    if (r < 60) return $urandom_range(win_now / 2);
    if (r < 90) return $urandom_range(win_now / 2, win_now);
    return $urandom_range(win_now + 1, 2 * win_now + 1);
  endfunction

  // Random polls. Most follow a finger that presses, moves and lifts, so that
  // slides and taps happen; the rest are faults, not-ready polls, polls with no
  // interrupt and fully random words.
  task automatic wander(input int polls);
    int         pick;
    int         d;
    int         cnt;
    logic [1:0] flt;
    repeat (polls) begin
      pick     = $urandom_range(99);
      clock_ms = clock_ms + ms_step();
      flt      = ($urandom_range(7) == 0) ? FLT_RSVD : FLT_OK;
      if (pick < 8) begin
        offer_poll(item_t'({$urandom, $urandom}));
      end else if (pick < 13) begin
        poke(1'b1, $urandom_range(1) ? FLT_STATUS : FLT_DATA, 1'b1,
             $urandom_range(1, max_now), $urandom_range(4095), $urandom_range(4095),
             clock_ms);
      end else if (pick < 18) begin
        poke(1'b1, flt, 1'b0, $urandom_range(15), $urandom_range(4095),
             $urandom_range(4095), clock_ms);
      end else if (pick < 21) begin
        poke(1'b0, 2'($urandom_range(3)), 1'($urandom_range(1)), $urandom_range(15),
             $urandom_range(4095), $urandom_range(4095), $urandom);
      end else if (!finger_down) begin
        fx          = $urandom_range(4095);
        fy          = $urandom_range(4095);
        finger_down = 1'b1;
        poke(1'b1, flt, 1'b1, $urandom_range(1, max_now), fx, fy, clock_ms);
      end else if ($urandom_range(3) == 0) begin
        // A lift is either a zero count or a count beyond the programmed maximum.
        cnt = (max_now < 15 && $urandom_range(1)) ? $urandom_range(max_now + 1, 15) : 0;
        finger_down = 1'b0;
        poke(1'b1, flt, 1'b1, cnt, $urandom_range(4095), $urandom_range(4095), clock_ms);
      end else begin
        case ($urandom_range(9))
          6, 7: begin
            // Exactly the threshold on the x axis, sometimes on y as well.
            d  = $urandom_range(1) ? thr_now : -thr_now;
            fx = clamp_coord(fx + d);
            fy = clamp_coord(fy + ($urandom_range(1) ? d : 0));
          end
          8: begin
            // Jump to the far corner, which gives the largest deltas.
            fx = fx < 2048 ? 4095 : 0;
            fy = fy < 2048 ? 4095 : 0;
          end
          9: begin
            fx = $urandom_range(4095);
            fy = $urandom_range(4095);
          end
          default: begin
            fx = clamp_coord(fx + int'($urandom_range(2 * thr_now)) - thr_now);
            fy = clamp_coord(fy + int'($urandom_range(2 * thr_now)) - thr_now);
          end
        endcase
        poke(1'b1, flt, 1'b1, $urandom_range(1, max_now), fx, fy, clock_ms);
      end
    end
  endtask

  // Quick press and lift pairs, enough of them to drive the tap count into saturation.
  task automatic tap_storm(input int taps);
    repeat (taps) begin
      clock_ms = clock_ms + $urandom_range(1, 40);
      poke(1'b1, FLT_OK, 1'b1, $urandom_range(1, max_now), $urandom_range(4095),
           $urandom_range(4095), clock_ms);
      clock_ms = clock_ms + $urandom_range(0, 40);
      poke(1'b1, FLT_OK, 1'b1, 0, $urandom_range(4095), $urandom_range(4095), clock_ms);
    end
    finger_down = 1'b0;
  endtask

  // The receiver takes reports with random stalls, and on request holds off for
  // a long stretch so the block fills up and pushes back on its input.
  initial begin : receiver
    int seen;
    seen       = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (park_asks != seen) begin
        seen = park_asks;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) begin
          @(negedge clk);
          out_tready <= 1'b0;
        end
      end else begin
        out_tready <= !(out_gaps && $urandom_range(99) < 17);
      end
    end
  end

  initial begin : stimulus
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    cfg_valid   = 1'b0;
    cfg_index   = REG_SLIDE_THRESHOLD;
    cfg_data    = '0;
    thr_now     = SLIDE_THRESHOLD_RST;
    win_now     = TAP_WINDOW_MS_RST;
    max_now     = MAX_POINTS_RST;
    fx          = 0;
    fy          = 0;
    finger_down = 1'b0;
    clock_ms    = 32'd1000;
    in_gaps     = 1'b1;
    out_gaps    = 1'b1;
    park_asks   = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed polls with the reset values of the registers (threshold 10, window 250,
    // five points).
    poke(1'b0, FLT_OK,     1'b1,  1,  100,  100, 32'd1000);   // no interrupt
    poke(1'b1, FLT_OK,     1'b1,  1,    0,    0, 32'd1000);   // press at the origin
    poke(1'b1, FLT_OK,     1'b1,  2,    3,    9, 32'd1010);   // small move stays down
    poke(1'b1, FLT_OK,     1'b1,  0,   77,   88, 32'd1050);   // quick lift, first tap
    poke(1'b1, FLT_OK,     1'b1,  5, 4095, 4095, 32'd1100);   // press from up, max count
    poke(1'b1, FLT_OK,     1'b1,  6,    1,    2, 32'd1200);   // count too large, second tap
    poke(1'b1, FLT_OK,     1'b1,  2, 2000, 2000, 32'd1300);
    poke(1'b1, FLT_OK,     1'b1,  2, 2010, 2000, 32'd1310);   // move of exactly the threshold
    poke(1'b1, FLT_OK,     1'b1,  2, 2011, 1999, 32'd1320);   // slide keeps going
    poke(1'b1, FLT_OK,     1'b0,  2, 2500, 2500, 32'd1330);   // not ready clears deltas
    poke(1'b1, FLT_STATUS, 1'b1,  1, 3000, 3000, 32'd1340);   // status read fault
    poke(1'b1, FLT_DATA,   1'b1,  3, 3000, 3000, 32'd1350);   // data read fault
    poke(1'b1, FLT_RSVD,   1'b1,  1,    0,    0, 32'd1360);   // reserved code acts as ok
    poke(1'b1, FLT_OK,     1'b1,  1, 4095, 4095, 32'd1370);   // largest positive delta
    poke(1'b1, FLT_OK,     1'b1,  1,    0,    0, 32'd1380);   // largest negative delta
    poke(1'b1, FLT_DATA,   1'b1, 15,    9,    9, 32'd1390);   // data fault ignored on lift
    poke(1'b1, FLT_DATA,   1'b1,  0,    9,    9, 32'd1400);   // slide end falls to none
    poke(1'b1, FLT_OK,     1'b1,  0,    9,    9, 32'd1410);
    poke(1'b1, FLT_OK,     1'b1,  1,  500,  600, 32'd2000);
    poke(1'b1, FLT_OK,     1'b1,  0,    0,    0, 32'd2251);   // held too long, no tap
    poke(1'b1, FLT_OK,     1'b1,  4,    5,    5, 32'd2300);
    poke(1'b1, FLT_OK,     1'b1,  0,    0,    0, 32'd2400);   // gap too long, run restarts
    poke(1'b1, FLT_OK,     1'b1,  3,    7,    7, 32'hFFFF_FFF0);
    poke(1'b1, FLT_OK,     1'b1,  0,    0,    0, 32'h0000_0010); // tick wraps inside a tap
    poke(1'b0, FLT_DATA,   1'b0, 15, 4095, 4095, 32'hFFFF_FFFF);

    // Smallest nonzero register values.
    drain();
    set_knobs(16'd1, 16'd1, 16'd1);
    clock_ms = $urandom;
    wander(300);

    // Largest register values, with no idling on either side for the whole phase.
    drain();
    in_gaps  = 1'b0;
    out_gaps = 1'b0;
    set_knobs(16'd4095, 16'd65535, 16'd15);
    clock_ms = $urandom;
    tap_storm(260);
    wander(280);

    // Mid values written with stray upper bits, a write to the unused index, a tick
    // about to wrap, and two long receiver hold-offs while polls keep coming.
    drain();
    in_gaps  = 1'b1;
    out_gaps = 1'b1;
    set_knobs(16'hA025, 16'd400, 16'h00F3);
    cfg_write(REG_UNUSED, 16'hFFFF);
    clock_ms = 32'hFFFF_0000;
    wander(20);
    park_asks = park_asks + 1;
    wander(180);
    park_asks = park_asks + 1;
    wander(180);

    // Back to the reset values.
    drain();
    set_knobs(16'd10, 16'd250, 16'd5);
    wander(350);

    drain();
    if (mismatch_total == 0) begin
      $display("** touch_gesture_tracker: PASSED **");
    end else begin
      $display("** touch_gesture_tracker: FAILED **");
    end
    $finish;
  end

  // Far beyond the slowest correct run: a stuck handshake or a missing report ends here.
  initial begin : watchdog
    #5_000_000;
    $display("** touch_gesture_tracker: FAILED **");
    $finish;
  end

endmodule

[touch_gesture_tracker.f]
+incdir+hdl
hdl/tgt_pkg.sv
hdl/tgt_cfg_regs.sv
hdl/tgt_core.sv
hdl/touch_gesture_tracker.sv
hdl/tgt_checker.sv
bench/touch_state_checker.sv
bench/tb_touch_gesture_tracker.sv
